FILE: rtl/core/assert_macros.svh
// assertion macros for the estimator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: rtl/core/ace_pkg.sv
// types and constants of the altitude estimator
package ace_pkg;
   localparam int unsigned OpAccel = 0;
   localparam int unsigned OpPosition = 1;

   localparam logic [2:0] CsrRangeBlend = 3'd0;
   localparam logic [2:0] CsrBaroBlend = 3'd1;
   localparam logic [2:0] CsrVelocityGain = 3'd2;
   localparam logic [2:0] CsrAccelDeadband = 3'd3;
   localparam logic [2:0] CsrVelocityDecay = 3'd4;
   localparam logic [2:0] CsrMaxSampleAge = 3'd5;

   typedef struct packed {
      logic        opcode;
      logic [31:0] accel_z;
      logic [31:0] range_z;
      logic [15:0] sample_age;
      logic [31:0] baro_alt;
      logic [15:0] time_step;
   } req_type;

   typedef struct packed {
      logic [31:0] altitude;
      logic [31:0] vertical_speed;
      logic [31:0] integrated_velocity;
      logic        surface_mode;
      logic        saturated;
   } rsp_type;
endpackage

FILE: rtl/core/ace_serial_mul.sv
// signed by unsigned shift-add multiplier, two bits per cycle
module ace_serial_mul #(
   parameter int AW = 66,
   parameter int BW = 18,
   parameter int PW = 84
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [AW-1:0]   a,
   input  logic        [BW-1:0]   b,
   output logic                   busy,
   output logic signed [PW-1:0]   p
);
   localparam int CW = $clog2(BW / 2 + 2);
   logic signed [PW-1:0] acc_ff, acc_in, mc_ff, mc_in;
   logic [BW-1:0] mp_ff, mp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic signed [PW-1:0] add0, add1;

   always_comb begin
      add0 = mp_ff[0] ? mc_ff : '0;
      add1 = mp_ff[1] ? (mc_ff <<< 1) : '0;
      acc_in = acc_ff;
      mc_in = mc_ff;
      mp_in = mp_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in = '0;
         mc_in = PW'(a);
         mp_in = b;
         cnt_in = CW'((BW + 1) / 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + add0 + add1;
         mc_in = mc_ff <<< 2;
         mp_in = mp_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff <= mc_in;
      mp_ff <= mp_in;
   end

   assign busy = busy_ff;
   assign p = acc_ff;
endmodule

FILE: rtl/core/ace_serial_div.sv
// restoring divider, one quotient bit per cycle, truncates toward zero
module ace_serial_div #(
   parameter int NW = 50,
   parameter int DW = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic        [DW-1:0] den,
   output logic                 busy,
   output logic signed [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0] r_ff, r_in, trial;
   logic [DW-1:0] d_ff, d_in;
   logic neg_ff, neg_in, busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW:0] shifted;

   always_comb begin
      shifted = {r_ff[DW-1:0], q_ff[NW-1]};
      trial = shifted - {1'b0, d_ff};
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in = num[NW-1] ? NW'(-num) : NW'(num);
         r_in = '0;
         d_in = den;
         neg_in = num[NW-1];
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DW]) begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
   end

   assign busy = busy_ff;
   assign quo = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule

FILE: rtl/core/altitude_complementary_estimator.sv
// top level of the altitude estimator: sequencer, multiplier and divider
//
// usage: one request beat on req_ (opcode selects acceleration or position
// update) yields exactly one response beat on rsp_. configuration registers
// are written on csr_ (index 0..5); the user must write them only while the
// block is idle, the block itself does not enforce it. csr_ready is always
// high and out-of-range indexes are dropped.
// an item runs through a sequencer that issues every product to one shared
// shift-add multiplier retiring two multiplier bits per cycle and the speed
// quotient to a bit-serial divider (one quotient bit per cycle). an acceleration
// item needs three products, a position item at most four products and the
// divider; a stale sample in surface mode or barometric seeding skips the two
// blend products (surface mode also skips the altitude update), a zero dt
// skips the divider. req_ready is high only in idle with no response waiting,
// so one item is at work at a time and a new item is taken only after the
// last response has been accepted.
// the response sits in an output register; a stalled receiver holds it and
// req_ready stays low until the beat is taken.
// reset (synchronous, active high) zeroes altitude, velocity, previous
// altitude, speed and the surface flag and loads the register defaults.
module altitude_complementary_estimator #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ace_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ace_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   `include "assert_macros.svh"

   localparam int AW = 66;
   // wide enough for the g constant up to 24 fraction bits
   localparam int BW = 28;
   localparam int PW = AW + BW;
   localparam int NW = 66;
   localparam logic signed [65:0] GConst =
      66'(((64'sd981 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
   localparam logic signed [65:0] SMax = 66'sd2147483647;
   localparam logic signed [65:0] SMin = -66'sd2147483648;

   typedef enum logic [4:0] {
      IDLE, A_DT, A_DTW, A_G, A_GW, A_DEC, A_DECW,
      P_VDT, P_VDTW, P_VG, P_VGW, P_OLD, P_OLDW, P_NEW, P_NEWW, P_ALT,
      P_DIV, P_DIVW, DONE
   } state_type;

   // configuration registers
   logic [15:0] range_blend_ff, baro_blend_ff, accel_db_ff, decay_ff, max_age_ff;
   logic [16:0] vgain_ff;

   state_type state_ff;
   ace_pkg::req_type req_ff;
   logic signed [65:0] alt_ff, vel_ff, prev_ff, speed_ff, t0_ff, t1_ff;
   logic follow_ff, sat_ff, upd_ff;
   logic rsp_valid_ff;
   ace_pkg::rsp_type rsp_ff;

   logic mul_start, mul_busy, div_start, div_busy;
   logic signed [AW-1:0] mul_a;
   logic [BW-1:0] mul_b;
   logic signed [PW-1:0] mul_p;
   logic signed [NW-1:0] div_q;

   // rounding shift by 16, ties toward plus infinity
   function automatic logic signed [65:0] rnd16(input logic signed [PW-1:0] x);
      logic signed [PW-1:0] y;
      y = x + PW'(32768);
      return 66'(y >>> 16);
   endfunction

   function automatic logic signed [65:0] rndf(input logic signed [PW-1:0] x);
      logic signed [PW-1:0] y;
      y = x + (PW'(1) <<< (FRAC_BITS - 1));
      return 66'(y >>> FRAC_BITS);
   endfunction

   function automatic logic signed [65:0] sat(input logic signed [65:0] x);
      if (x > SMax) return SMax;
      if (x < SMin) return SMin;
      return x;
   endfunction

   function automatic logic clip(input logic signed [65:0] x);
      return (x > SMax) || (x < SMin);
   endfunction

   ace_serial_mul #(.AW(AW), .BW(BW), .PW(PW)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(mul_a), .b(mul_b), .busy(mul_busy), .p(mul_p)
   );

   ace_serial_div #(.NW(NW), .DW(16)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num((t0_ff - prev_ff) <<< 16), .den(req_ff.time_step),
      .busy(div_busy), .quo(div_q)
   );

   // deadbanded acceleration
   logic signed [65:0] acc_a, acc_db, acc_mag, acc_d;
   always_comb begin
      acc_a = 66'($signed(req_ff.accel_z));
      acc_db = rnd16(PW'({1'b0, accel_db_ff}) <<< FRAC_BITS);
      acc_mag = acc_a[65] ? -acc_a : acc_a;
      if (acc_mag < acc_db) acc_d = '0;
      else if (acc_a > 0) acc_d = acc_a - acc_db;
      else acc_d = acc_a + acc_db;
   end

   // operand selection per state
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         A_DT: begin
            mul_a = acc_d; mul_b = BW'(req_ff.time_step); mul_start = 1'b1;
         end
         A_G: begin
            // scaled step times g, g as the multiplier digit operand
            mul_a = t0_ff; mul_b = BW'(GConst); mul_start = 1'b1;
         end
         A_DEC: begin
            mul_a = t0_ff; mul_b = BW'(decay_ff); mul_start = 1'b1;
         end
         P_VDT: begin
            mul_a = vel_ff; mul_b = BW'(req_ff.time_step); mul_start = 1'b1;
         end
         P_VG: begin
            mul_a = t0_ff; mul_b = BW'(vgain_ff); mul_start = 1'b1;
         end
         P_OLD: begin
            mul_a = alt_ff;
            mul_b = BW'(follow_ff ? range_blend_ff : baro_blend_ff);
            mul_start = 1'b1;
         end
         P_NEW: begin
            mul_a = follow_ff ? 66'($signed(req_ff.range_z)) : 66'($signed(req_ff.baro_alt));
            mul_b = BW'(17'd65536 - {1'b0, follow_ff ? range_blend_ff : baro_blend_ff});
            mul_start = 1'b1;
         end
         P_DIV: div_start = (req_ff.time_step != '0);
         default: ;
      endcase
   end

   logic fresh_now;
   assign fresh_now = req_data.sample_age <= max_age_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
         alt_ff <= '0; vel_ff <= '0; prev_ff <= '0; speed_ff <= '0;
         follow_ff <= 1'b0;
         range_blend_ff <= 16'd58982; baro_blend_ff <= 16'd65339;
         vgain_ff <= 17'd65536; accel_db_ff <= 16'd2621;
         decay_ff <= 16'd65208; max_age_ff <= 16'd50;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               ace_pkg::CsrRangeBlend: range_blend_ff <= csr_wdata[15:0];
               ace_pkg::CsrBaroBlend: baro_blend_ff <= csr_wdata[15:0];
               ace_pkg::CsrVelocityGain: vgain_ff <= csr_wdata[16:0];
               ace_pkg::CsrAccelDeadband: accel_db_ff <= csr_wdata[15:0];
               ace_pkg::CsrVelocityDecay: decay_ff <= csr_wdata[15:0];
               ace_pkg::CsrMaxSampleAge: max_age_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: if (req_valid && !rsp_valid_ff) begin
               req_ff <= req_data;
               sat_ff <= 1'b0;
               if (req_data.opcode == 1'(ace_pkg::OpAccel)) state_ff <= A_DT;
               else begin
                  if (fresh_now) follow_ff <= 1'b1;
                  upd_ff <= fresh_now || !follow_ff;
                  state_ff <= P_VDT;
               end
            end
            A_DT: state_ff <= A_DTW;
            A_DTW: if (!mul_busy) begin
               t0_ff <= rnd16(mul_p);
               state_ff <= A_G;
            end
            A_G: state_ff <= A_GW;
            // velocity after integration, clipped before the decay
            A_GW: if (!mul_busy) begin
               t0_ff <= sat(vel_ff + rndf(mul_p));
               sat_ff <= sat_ff | clip(vel_ff + rndf(mul_p));
               state_ff <= A_DEC;
            end
            A_DEC: state_ff <= A_DECW;
            A_DECW: if (!mul_busy) begin
               sat_ff <= sat_ff | clip(rnd16(mul_p));
               vel_ff <= sat(rnd16(mul_p));
               state_ff <= DONE;
            end
            P_VDT: state_ff <= P_VDTW;
            P_VDTW: if (!mul_busy) begin
               t0_ff <= rnd16(mul_p);
               state_ff <= P_VG;
            end
            P_VG: state_ff <= P_VGW;
            P_VGW: if (!mul_busy) begin
               t1_ff <= rnd16(mul_p);
               if (follow_ff && !upd_ff) begin
                  t0_ff <= alt_ff;
                  state_ff <= P_DIV;
               end else if (!follow_ff && alt_ff == '0) begin
                  t0_ff <= 66'($signed(req_ff.baro_alt)) <<< 16;
                  state_ff <= P_ALT;
               end else state_ff <= P_OLD;
            end
            P_OLD: state_ff <= P_OLDW;
            P_OLDW: if (!mul_busy) begin
               t0_ff <= 66'(mul_p);
               state_ff <= P_NEW;
            end
            P_NEW: state_ff <= P_NEWW;
            P_NEWW: if (!mul_busy) begin
               t0_ff <= t0_ff + 66'(mul_p);
               state_ff <= P_ALT;
            end
            P_ALT: begin
               t0_ff <= sat(rnd16(PW'(t0_ff)) + t1_ff);
               alt_ff <= sat(rnd16(PW'(t0_ff)) + t1_ff);
               sat_ff <= sat_ff | clip(rnd16(PW'(t0_ff)) + t1_ff);
               state_ff <= P_DIV;
            end
            P_DIV: state_ff <= P_DIVW;
            P_DIVW: if (!div_busy) begin
               if (req_ff.time_step == '0) speed_ff <= '0;
               else begin
                  speed_ff <= sat(div_q);
                  sat_ff <= sat_ff | clip(div_q);
               end
               prev_ff <= t0_ff;
               state_ff <= DONE;
            end
            DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.altitude <= alt_ff[31:0];
               rsp_ff.vertical_speed <= speed_ff[31:0];
               rsp_ff.integrated_velocity <= vel_ff[31:0];
               rsp_ff.surface_mode <= follow_ff;
               rsp_ff.saturated <= sat_ff;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

   `ASSERT_IMPLIES(a_ready_idle, clock, reset, req_ready, state_ff == IDLE)
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != IDLE)
   `ASSERT_IMPLIES(a_no_rsp_busy, clock, reset, rsp_valid, state_ff == IDLE)
   `ASSERT_NEXT(a_sticky_follow, clock, reset, follow_ff, follow_ff)
endmodule
